// ===== rtl/core/ffai_pkg.sv =====
// Shared types and constants of the force-filtered admittance integrator.
// No dependencies; imported by ffai_mul, ffai_window and the top level (not by ffai_ram).
`timescale 1ns / 1ps

package ffai_pkg;

  localparam int unsigned WindowDefault = 16;

  localparam logic [30:0] InvMassReset  = 31'd13107;
  localparam logic [30:0] DampingReset  = 31'd327680;
  localparam logic [30:0] StiffReset    = 31'd327680;
  localparam logic [31:0] TimeStepReset = 32'd4294967;
  localparam logic [31:0] BasePosReset  = 32'd0;

  typedef enum logic [2:0] {
    REG_INV_MASS = 3'd0,
    REG_DAMPING  = 3'd1,
    REG_STIFF    = 3'd2,
    REG_TSTEP    = 3'd3,
    REG_BASE_POS = 3'd4
  } ffai_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_WAIT,
    ST_NET,
    ST_MACC,
    ST_ACC,
    ST_MDV,
    ST_VEL,
    ST_MDX,
    ST_POS,
    ST_OUT
  } ffai_state_e;

  typedef struct packed {
    logic push;
    logic start;
  } ffai_win_ctrl_t;

  typedef struct packed {
    logic               avg_valid;
    logic signed [31:0] avg;
  } ffai_win_stat_t;

endpackage

// ===== rtl/core/ffai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffai_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/ffai_mul.sv =====
// Shared signed-by-unsigned 32x32 multiplier with registered product.
// Depends on ffai_pkg.
`timescale 1ns / 1ps

module ffai_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic        [31:0] b_i,
  output logic signed [63:0] p_o
);
  import ffai_pkg::*;

  logic signed [65:0] prod;

  assign prod = $signed({a_i[31], a_i}) * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    p_o <= prod[63:0];
  end

endmodule

// ===== rtl/core/ffai_window.sv =====
// Force sample ring, running sum and moving average (shift or reciprocal divide).
// Depends on ffai_pkg and ffai_ram.
`timescale 1ns / 1ps

module ffai_window #(
  parameter int unsigned WINDOW = ffai_pkg::WindowDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ffai_pkg::ffai_win_ctrl_t ctrl_i,
  input  logic signed [31:0]       force_i,
  output ffai_pkg::ffai_win_stat_t stat_o
);
  import ffai_pkg::*;

  localparam int unsigned IdxW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned LogW   = $clog2(WINDOW);
  localparam int unsigned SumW   = 32 + LogW;
  localparam bit          IsPow2 = ((1 << LogW) == WINDOW);
  // |sum| is split into a high part and 16 low bits; both steps use one reciprocal
  localparam int unsigned NumW   = 16 + LogW;
  localparam int unsigned Shift  = NumW + LogW;
  localparam int unsigned RecW   = NumW + 2;
  localparam int unsigned PrdW   = NumW + RecW;
  localparam logic [63:0] RecFull =
    ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RecW-1:0] Recip = RecFull[RecW-1:0];

  logic [IdxW-1:0]        idx_q;
  logic                   full_q;
  logic signed [SumW-1:0] sum_q;
  logic [31:0]            rdata;
  logic signed [31:0]     old_f;
  logic signed [SumW-1:0] pow2_avg;
  logic [SumW-1:0]        mag;

  logic                   neg_q;
  logic [15:0]            lo_q;
  logic [NumW-1:0]        num_q;
  logic [NumW-1:0]        quo_q;
  logic [15:0]            qhi_q;
  logic [1:0]             phase_q;
  logic                   busy_q;
  logic                   valid_q;
  logic signed [31:0]     avg_q;
  logic [PrdW-1:0]        recip_prod;
  logic [NumW-1:0]        quo;
  logic [NumW-1:0]        rem;
  logic [31:0]            quo_full;

  ffai_ram #(
    .WIDTH(32),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.push),
    .waddr_i(idx_q),
    .wdata_i(force_i),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  // slots not yet written since reset read as zero
  assign old_f      = full_q ? $signed(rdata) : 32'sd0;
  assign pow2_avg   = (sum_q + (sum_q[SumW-1] ? SumW'(WINDOW - 1) : SumW'(0))) >>> LogW;
  assign mag        = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign recip_prod = PrdW'(num_q) * PrdW'(Recip);
  assign quo        = NumW'(recip_prod >> Shift);
  assign rem        = num_q - quo_q * NumW'(WINDOW);
  assign quo_full   = {qhi_q, quo_q[15:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      phase_q <= '0;
    end else begin
      if (ctrl_i.push) begin
        sum_q <= sum_q + SumW'(force_i) - SumW'(old_f);
        if (idx_q == IdxW'(WINDOW - 1)) begin
          idx_q  <= '0;
          full_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (ctrl_i.start) begin
        if (IsPow2) begin
          valid_q <= 1'b1;
        end else begin
          valid_q <= 1'b0;
          busy_q  <= 1'b1;
          phase_q <= '0;
        end
      end else if (busy_q) begin
        phase_q <= phase_q + 1'b1;
        if (phase_q == 2'd3) begin
          busy_q  <= 1'b0;
          valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      avg_q <= pow2_avg[31:0];
      neg_q <= sum_q[SumW-1];
      lo_q  <= mag[15:0];
      num_q <= mag[SumW-1:16];
    end else if (busy_q) begin
      unique case (phase_q)
        2'd0, 2'd2: begin
          quo_q <= quo;
        end
        2'd1: begin
          qhi_q <= quo_q[15:0];
          num_q <= (rem << 16) | NumW'(lo_q);
        end
        2'd3: begin
          avg_q <= neg_q ? -$signed(quo_full) : $signed(quo_full);
        end
      endcase
    end
  end

  assign stat_o.avg_valid = valid_q;
  assign stat_o.avg       = avg_q;

endmodule

// ===== rtl/core/force_filtered_admittance_integrator.sv =====
// Top level: sequencer, gain registers and admittance integrator state.
// Depends on ffai_pkg, ffai_window and ffai_mul.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  force_z_i
//   out       output     out_valid_o/out_ready_i filtered_force_o, displacement_o,
//                                                commanded_height_o
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item passes through five products chained through the one shared multiplier;
// WINDOW values other than a power of two add the reciprocal averaging divider.
// Reset is asynchronous; ring slots read as zero until first written.
// One finished result waits in the output register while the next item is accepted;
// the sequencer holds in its last state while that register is still full.
`timescale 1ns / 1ps

module force_filtered_admittance_integrator #(
  parameter int unsigned WINDOW = ffai_pkg::WindowDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] force_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] filtered_force_o,
  output logic signed [31:0] displacement_o,
  output logic signed [31:0] commanded_height_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import ffai_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  ffai_state_e state_q, state_d;

  logic [30:0]        inv_mass_q, damping_q, stiff_q;
  logic [31:0]        tstep_q;
  logic signed [31:0] base_q;

  logic signed [31:0] f_q, v_q, x_q, net_q, acc_q;
  logic signed [47:0] bv_q;
  logic               out_valid_q;
  logic signed [31:0] out_avg_q, out_x_q, out_h_q;

  ffai_win_ctrl_t     win_ctrl;
  ffai_win_stat_t     win_stat;
  logic signed [31:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [63:0] prod;
  logic               out_load;

  logic signed [49:0] net_sum;
  logic signed [32:0] v_sum, x_sum, h_sum;

  ffai_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .force_i(f_q),
    .stat_o (win_stat)
  );

  ffai_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign net_sum = 50'(win_stat.avg) - 50'(bv_q) - 50'($signed(prod[63:16]));
  assign v_sum   = 33'(v_q) + 33'($signed(prod[63:32]));
  assign x_sum   = 33'(x_q) + 33'($signed(prod[63:32]));
  assign h_sum   = 33'(base_q) + 33'(x_q);

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    win_ctrl.push  = 1'b0;
    win_ctrl.start = 1'b0;
    out_load       = 1'b0;
    // default operands keep K*x in the product register
    mul_a          = x_q;
    mul_b          = {1'b0, stiff_q};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        win_ctrl.push = 1'b1;
        mul_a         = v_q;
        mul_b         = {1'b0, damping_q};
        state_d       = ST_AVG;
      end
      ST_AVG: begin
        win_ctrl.start = 1'b1;
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        if (win_stat.avg_valid) begin
          state_d = ST_NET;
        end
      end
      ST_NET: begin
        state_d = ST_MACC;
      end
      ST_MACC: begin
        mul_a   = net_q;
        mul_b   = {1'b0, inv_mass_q};
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_MDV;
      end
      ST_MDV: begin
        mul_a   = acc_q;
        mul_b   = tstep_q;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        state_d = ST_MDX;
      end
      ST_MDX: begin
        mul_a   = v_q;
        mul_b   = tstep_q;
        state_d = ST_POS;
      end
      ST_POS: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= InvMassReset;
      damping_q   <= DampingReset;
      stiff_q     <= StiffReset;
      tstep_q     <= TimeStepReset;
      base_q      <= BasePosReset;
      v_q         <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_INV_MASS: inv_mass_q <= cfg_data_i[30:0];
          REG_DAMPING:  damping_q  <= cfg_data_i[30:0];
          REG_STIFF:    stiff_q    <= cfg_data_i[30:0];
          REG_TSTEP:    tstep_q    <= cfg_data_i;
          REG_BASE_POS: base_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_VEL) begin
        v_q <= sat32(66'(v_sum));
      end
      if (state_q == ST_POS) begin
        x_q <= sat32(66'(x_sum));
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      f_q <= force_z_i;
    end
    if (state_q == ST_AVG) begin
      bv_q <= prod[63:16];
    end
    if (state_q == ST_NET) begin
      net_q <= sat32(66'(net_sum));
    end
    if (state_q == ST_ACC) begin
      acc_q <= sat32(66'($signed(prod[63:16])));
    end
    if (out_load) begin
      out_avg_q <= win_stat.avg;
      out_x_q   <= x_q;
      out_h_q   <= sat32(66'(h_sum));
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign filtered_force_o   = out_avg_q;
  assign displacement_o     = out_x_q;
  assign commanded_height_o = out_h_q;

endmodule
